[sv/assert_macros.svh]
// Assertion helpers for the allocator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator check failed");

// Check a property on every clock edge, reset included.
`define CBA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");

`endif

[sv/cba_pkg.sv]
package cba_pkg;

  localparam int unsigned BLOCKS_DEF = 256;
  localparam int unsigned SLOTS_DEF  = 64;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_DEL   = 2'd1,
    CMD_PLACE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_DENIED   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

endpackage

[sv/cba_if.sv]
interface cba_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] file_key;
  logic [8:0]  length;
  logic [7:0]  start_block;
  logic [15:0] owner_id;
  logic [7:0]  owner_priority;

  modport source (output valid, cmd, file_key, length, start_block, owner_id,
                  owner_priority, input ready);
  modport sink (input valid, cmd, file_key, length, start_block, owner_id,
                owner_priority, output ready);
endinterface

interface cba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] alloc_start;
  logic [5:0] slot_index;

  modport source (output valid, status, alloc_start, slot_index, input ready);
  modport sink (input valid, status, alloc_start, slot_index, output ready);
endinterface

[sv/contiguous_block_allocator.sv]
// Channel  Dir  Word
// cmd_i    in   cmd, file_key, length, start_block, owner_id, owner_priority
// rsp_o    out  status, alloc_start, slot_index
//
// One command at a time; cmd_i.ready is high only when no command is in flight.
// Add: a free-slot search, then a one-block-per-cycle bitmap walk for a free run,
// then its blocks are marked one at a time; Place skips the walk, marks from start_block.
// Delete: read each slot (S_DREQ, table read port), check it (S_DCHK); free its blocks.
// Reset clears the bitmap, slot valid bits and file count at once.
// A result waits in the output register until rsp_o.ready.
module contiguous_block_allocator #(
  parameter int unsigned BLOCKS = cba_pkg::BLOCKS_DEF,
  parameter int unsigned SLOTS  = cba_pkg::SLOTS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  cba_cmd_if.sink   cmd_i,
  cba_rsp_if.source rsp_o
);

  localparam int unsigned BW  = $clog2(BLOCKS);
  localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SBW = (BW > 8) ? BW : 8;
  localparam int unsigned BCW = SBW + 1;
  localparam int unsigned RW  = $clog2(BLOCKS + 1);
  localparam int unsigned LW  = (RW > 9) ? RW : 9;
  localparam int unsigned CW  = $clog2(SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FSLOT = 7'b0000010,
    S_BSCAN = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_DREQ  = 7'b0010000,
    S_DCHK  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [31:0]    key;
    logic [15:0]    owner;
    logic [SBW-1:0] start;
    logic [8:0]     len;
  } entry_t;

  state_e            state_q, state_d;
  cba_pkg::cmd_e     cmd_q, cmd_d;
  logic [31:0]       key_q, key_d;
  logic [8:0]        len_q, len_d;
  logic [7:0]        sb_q, sb_d;
  logic [15:0]       pid_q, pid_d;
  logic              prio0_q, prio0_d;
  logic [SW-1:0]     sidx_q, sidx_d;
  logic [BCW-1:0]    b_q, b_d;
  logic [8:0]        cnt_q, cnt_d;
  logic [LW-1:0]     run_q, run_d;
  logic [BW-1:0]     rstart_q, rstart_d;
  logic              mark_q, mark_d;
  logic [BLOCKS-1:0] used_q, used_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [CW-1:0]     count_q, count_d;
  cba_pkg::status_e  status_q, status_d;
  logic [SBW-1:0]    ostart_q, ostart_d;
  logic [SW-1:0]     slot_q, slot_d;

  entry_t            mem [SLOTS];
  entry_t            rd_q;
  logic              we;
  entry_t            wdata;

  logic [BW-1:0]     bidx;
  logic [BW-1:0]     run_start;

  assign bidx      = b_q[BW-1:0];
  assign run_start = (run_q == '0) ? bidx : rstart_q;

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = (state_q == S_RESP);
  assign rsp_o.status      = status_q;
  assign rsp_o.alloc_start = ostart_q[7:0];
  assign rsp_o.slot_index  = 6'(slot_q);

  assign wdata = '{key: key_q, owner: pid_q, start: ostart_q, len: len_q};

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    len_d    = len_q;
    sb_d     = sb_q;
    pid_d    = pid_q;
    prio0_d  = prio0_q;
    sidx_d   = sidx_q;
    b_d      = b_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    rstart_d = rstart_q;
    mark_d   = mark_q;
    used_d   = used_q;
    valid_d  = valid_q;
    count_d  = count_q;
    status_d = status_q;
    ostart_d = ostart_q;
    slot_d   = slot_q;
    we       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d    = cba_pkg::cmd_e'(cmd_i.cmd);
          key_d    = cmd_i.file_key;
          len_d    = cmd_i.length;
          sb_d     = cmd_i.start_block;
          pid_d    = cmd_i.owner_id;
          prio0_d  = (cmd_i.owner_priority == 8'd0);
          sidx_d   = '0;
          status_d = cba_pkg::ST_OK;
          ostart_d = '0;
          slot_d   = '0;
          case (cba_pkg::cmd_e'(cmd_i.cmd))
            cba_pkg::CMD_ADD, cba_pkg::CMD_PLACE: state_d = S_FSLOT;
            cba_pkg::CMD_DEL:                     state_d = S_DREQ;
            default:                              state_d = S_RESP;
          endcase
        end
      end
      S_FSLOT: begin
        if (count_q == CW'(SLOTS)) begin
          status_d = cba_pkg::ST_FULL;
          state_d  = S_RESP;
        end else if (!valid_q[sidx_q]) begin
          slot_d = sidx_q;
          if (cmd_q == cba_pkg::CMD_ADD) begin
            b_d     = '0;
            run_d   = '0;
            state_d = S_BSCAN;
          end else begin
            b_d      = BCW'(sb_q);
            cnt_d    = len_q;
            mark_d   = 1'b1;
            ostart_d = SBW'(sb_q);
            state_d  = S_MARK;
          end
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      S_BSCAN: begin
        if (used_q[bidx]) begin
          run_d = '0;
        end else begin
          rstart_d = run_start;
          run_d    = run_q + 1'b1;
        end
        if (!used_q[bidx] && (LW'(run_q + 1'b1) == LW'(len_q))) begin
          b_d      = BCW'(run_start);
          cnt_d    = len_q;
          mark_d   = 1'b1;
          ostart_d = SBW'(run_start);
          state_d  = S_MARK;
        end else if (b_q == BCW'(BLOCKS - 1)) begin
          status_d = cba_pkg::ST_NOSPACE;
          slot_d   = '0;
          state_d  = S_RESP;
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      S_MARK: begin
        if (cnt_q == 9'd0 || b_q >= BCW'(BLOCKS)) begin
          if (mark_q) begin
            we              = 1'b1;
            valid_d[slot_q] = 1'b1;
            count_d         = count_q + 1'b1;
          end
          state_d = S_RESP;
        end else begin
          used_d[bidx] = mark_q;
          b_d          = b_q + 1'b1;
          cnt_d        = cnt_q - 1'b1;
        end
      end
      S_DREQ: begin
        state_d = S_DCHK;
      end
      S_DCHK: begin
        if (valid_q[sidx_q] && rd_q.key == key_q) begin
          if (rd_q.owner != pid_q && !prio0_q) begin
            status_d = cba_pkg::ST_DENIED;
          end else begin
            valid_d[sidx_q] = 1'b0;
            count_d         = count_q - 1'b1;
            slot_d          = sidx_q;
            b_d             = BCW'(rd_q.start);
            cnt_d           = rd_q.len;
            mark_d          = 1'b0;
            ostart_d        = rd_q.start;
          end
          state_d = (rd_q.owner != pid_q && !prio0_q) ? S_RESP : S_MARK;
        end else if (sidx_q == SW'(SLOTS - 1)) begin
          status_d = cba_pkg::ST_NOTFOUND;
          state_d  = S_RESP;
        end else begin
          sidx_d  = sidx_q + 1'b1;
          state_d = S_DREQ;
        end
      end
      S_RESP: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      valid_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    len_q    <= len_d;
    sb_q     <= sb_d;
    pid_q    <= pid_d;
    prio0_q  <= prio0_d;
    sidx_q   <= sidx_d;
    b_q      <= b_d;
    cnt_q    <= cnt_d;
    run_q    <= run_d;
    rstart_q <= rstart_d;
    mark_q   <= mark_d;
    status_q <= status_d;
    ostart_q <= ostart_d;
    slot_q   <= slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[slot_q] <= wdata;
    end
    rd_q <= mem[sidx_q];
  end

endmodule

[sv/cba_checker.sv]
`include "assert_macros.svh"

module cba_checker (
  input logic       clk_i,
  input logic       rst_ni,
  cba_cmd_if.sink   cmd_i,
  cba_rsp_if.source rsp_o
);

  logic rsp_error;
  logic rsp_zero;

  assign rsp_error = rsp_o.valid && (rsp_o.status != cba_pkg::ST_OK);
  assign rsp_zero  = (rsp_o.alloc_start == 8'd0) && (rsp_o.slot_index == 6'd0);

  `CBA_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
  `CBA_ASSERT(a_no_overlap, clk_i, rst_ni, rsp_o.valid |-> !cmd_i.ready)
  `CBA_ASSERT(a_busy_after_accept, clk_i, rst_ni, cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
  `CBA_ASSERT(a_error_zero, clk_i, rst_ni, rsp_error |-> rsp_zero)
  `CBA_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !rsp_o.valid)

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cmd_i  (cmd_i),
  .rsp_o  (rsp_o)
);
